// File: sv/abt_pkg.sv
package abt_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 17;
  localparam int OPC_W  = 6;
  localparam int IMM_W  = 64;

  localparam int DEF_NUM_REGISTERS     = 16;
  localparam int DEF_NUM_ACCUMULATORS  = 4;
  localparam int DEF_MAX_OPS           = 256;
  localparam int DEF_MAX_PROGRAM_WORDS = 65536;

  typedef enum logic [3:0] {
    K_U16CONST = 4'd0,
    K_I16CONST = 4'd1,
    K_INTCONST = 4'd2,
    K_LOADCOL  = 4'd3,
    K_MOV      = 4'd4,
    K_ADD      = 4'd5,
    K_SUB      = 4'd6,
    K_MUL      = 4'd7,
    K_SUM      = 4'd8,
    K_EXIT     = 4'd9
  } op_kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_MALFORMED   = 3'd1,
    ST_NONBIGINT   = 3'd2,
    ST_RANGE       = 3'd3,
    ST_UNSUPPORTED = 3'd4,
    ST_TOOLARGE    = 3'd5
  } status_t;

  localparam logic [OPC_W-1:0] OPC_LOADCOL   = 6'd7;
  localparam logic [OPC_W-1:0] OPC_LOADCONST = 6'd8;
  localparam logic [OPC_W-1:0] OPC_MOV       = 6'd9;
  localparam logic [OPC_W-1:0] OPC_SUM       = 6'd14;
  localparam logic [OPC_W-1:0] OPC_ADD       = 6'd20;
  localparam logic [OPC_W-1:0] OPC_SUB       = 6'd22;
  localparam logic [OPC_W-1:0] OPC_MUL       = 6'd24;

  localparam logic [4:0] TYPE_BIGINT = 5'd9;

  // deferred checks of a load-constant, reported on its last word
  localparam logic [1:0] CHK_OK    = 2'd0;
  localparam logic [1:0] CHK_TYPE  = 2'd1;
  localparam logic [1:0] CHK_RANGE = 2'd2;

  typedef struct packed {
    op_kind_t                kind;
    logic [3:0]              dst_a;
    logic [3:0]              src_b;
    logic [7:0]              src_c;
    logic signed [IMM_W-1:0] imm;
    status_t                 status;
    logic [POS_W-1:0]        pos;
    logic [OPC_W-1:0]        opc;
    logic                    last;
  } res_t;

  function automatic res_t mk_op(op_kind_t kind, logic [3:0] a, logic [3:0] b,
                                 logic [7:0] c, logic [IMM_W-1:0] imm, logic last);
    res_t r;
    r.kind   = kind;
    r.dst_a  = a;
    r.src_b  = b;
    r.src_c  = c;
    r.imm    = imm;
    r.status = ST_OK;
    r.pos    = '0;
    r.opc    = '0;
    r.last   = last;
    return r;
  endfunction

  function automatic res_t mk_err(status_t st, logic [POS_W-1:0] pos,
                                  logic [OPC_W-1:0] opc);
    res_t r;
    r.kind   = K_U16CONST;
    r.dst_a  = '0;
    r.src_b  = '0;
    r.src_c  = '0;
    r.imm    = '0;
    r.status = st;
    r.pos    = pos;
    r.opc    = opc;
    r.last   = 1'b1;
    return r;
  endfunction

endpackage

// File: sv/aggregation_bytecode_translator_top.sv
// aggregation bytecode translator
// input channel: one bytecode word per item (in_word, in_has_word, in_is_last)
// under in_valid / in_stall; an item is taken when in_valid is high and in_stall
// low. an item with in_has_word low carries no word and only ends the program
// when in_is_last is set.
// result channel: translated ops and errors, each shown on out_* under
// out_valid / out_stall, taken when out_valid is high and out_stall low.
// results of an item are registered in a four-entry result queue and shown on
// out_* from its head. throughput: one word per cycle while in_stall is low;
// decode is plain field extraction and compares between the input ports and
// the queue. the last item may yield two results (final op, then exit or error).
// the first error ends the program with one result; later items up to the
// one with in_is_last are swallowed without results.
// in_stall rises while fewer than two queue slots are free, so a stalled
// receiver backs up into the input after at most four queued results.
// reset (rst_n low, synchronous) empties the queue and returns the decoder to
// the start of a program; the item that ends a program resets the decoder alone.
module aggregation_bytecode_translator_top
  import abt_pkg::*;
#(
  parameter int NUM_REGISTERS     = DEF_NUM_REGISTERS,
  parameter int NUM_ACCUMULATORS  = DEF_NUM_ACCUMULATORS,
  parameter int MAX_OPS           = DEF_MAX_OPS,
  parameter int MAX_PROGRAM_WORDS = DEF_MAX_PROGRAM_WORDS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [WORD_W-1:0]       in_word,
  input  logic                    in_has_word,
  input  logic                    in_is_last,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [3:0]              out_op_kind,
  output logic [3:0]              out_dst_a,
  output logic [3:0]              out_src_b,
  output logic [7:0]              out_src_c,
  output logic signed [IMM_W-1:0] out_immediate,
  output logic [2:0]              out_status,
  output logic [POS_W-1:0]        out_offending_position,
  output logic [OPC_W-1:0]        out_offending_opcode,
  output logic                    out_last
);

  localparam int OPS_W = $clog2(MAX_OPS + 1);
  localparam logic [OPS_W-1:0] OPS_LIMIT = OPS_W'(MAX_OPS);
  localparam logic [POS_W-1:0] WP_LIMIT  = POS_W'(MAX_PROGRAM_WORDS);
  localparam logic [4:0]       NREG      = 5'(NUM_REGISTERS);
  localparam logic [16:0]      NACC      = 17'(NUM_ACCUMULATORS);

  localparam int QDEPTH = 4;
  localparam int QP_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_INSTR   = 2'd0,
    PH_LOW     = 2'd1,
    PH_HIGH    = 2'd2,
    PH_DISCARD = 2'd3
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [POS_W-1:0]  wp_r, wp_nxt;
  logic [OPS_W-1:0]  ops_r, ops_nxt;
  logic [3:0]        preg_r, preg_nxt;
  logic [1:0]        pchk_r, pchk_nxt;
  logic [POS_W-1:0]  pstart_r, pstart_nxt;
  logic [WORD_W-1:0] low_r, low_nxt;

  res_t              q_r [QDEPTH];
  logic [QP_W-1:0]   head_r, tail_r;
  logic [QC_W-1:0]   count_r;

  logic              in_acc, out_acc;
  logic [1:0]        n_res;
  res_t              res0, res1;

  logic [OPC_W-1:0]  opc;
  logic [4:0]        wtype;
  logic [3:0]        r16, fd, fs;
  logic [15:0]       lo16;
  logic [IMM_W-1:0]  cval;
  op_kind_t          kind;
  logic [3:0]        fa, fb;
  logic [7:0]        fc;
  status_t           err;
  logic [POS_W-1:0]  err_pos;
  logic [OPC_W-1:0]  err_opc;
  logic              op_ok;

  assign in_stall  = count_r > QC_W'(QDEPTH - 2);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = count_r != '0;
  assign out_acc   = out_valid && !out_stall;

  assign opc   = in_word[31:26];
  assign wtype = in_word[25:21];
  assign r16   = in_word[19:16];
  assign lo16  = in_word[15:0];
  assign fd    = in_word[15:12];
  assign fs    = in_word[11:8];
  assign cval  = {in_word, low_r};

  always_comb begin
    phase_nxt  = phase_r;
    wp_nxt     = wp_r;
    ops_nxt    = ops_r;
    preg_nxt   = preg_r;
    pchk_nxt   = pchk_r;
    pstart_nxt = pstart_r;
    low_nxt    = low_r;
    n_res      = 2'd0;
    res0       = mk_op(K_U16CONST, '0, '0, '0, '0, 1'b0);
    res1       = res0;
    kind       = K_U16CONST;
    fa         = '0;
    fb         = '0;
    fc         = '0;
    err        = ST_OK;
    err_pos    = '0;
    err_opc    = '0;
    op_ok      = 1'b0;

    if (in_acc) begin
      if (phase_r == PH_DISCARD) begin
        if (in_is_last) begin
          phase_nxt  = PH_INSTR;
          wp_nxt     = '0;
          ops_nxt    = '0;
          preg_nxt   = '0;
          pchk_nxt   = CHK_OK;
          pstart_nxt = '0;
          low_nxt    = '0;
        end
      end else begin
        if (in_has_word) begin
          if (wp_r < WP_LIMIT) wp_nxt = wp_r + 1'b1;
          case (phase_r)
            PH_INSTR: begin
              err_pos = wp_r;
              err_opc = opc;
              case (opc)
                OPC_LOADCONST: begin
                  preg_nxt   = r16;
                  pchk_nxt   = (wtype != TYPE_BIGINT) ? CHK_TYPE :
                               (({1'b0, r16} >= NREG) ? CHK_RANGE : CHK_OK);
                  pstart_nxt = wp_r;
                  phase_nxt  = PH_LOW;
                end
                OPC_LOADCOL: begin
                  if (wtype != TYPE_BIGINT) err = ST_NONBIGINT;
                  else if (({1'b0, r16} >= NREG) || (|lo16[15:8])) err = ST_RANGE;
                  kind = K_LOADCOL;
                  fa   = r16;
                  fc   = lo16[7:0];
                end
                OPC_MOV, OPC_ADD, OPC_SUB, OPC_MUL: begin
                  if (({1'b0, fd} >= NREG) || ({1'b0, fs} >= NREG)) err = ST_RANGE;
                  fa = fd;
                  if (opc == OPC_MOV) begin
                    kind = K_MOV;
                    fb   = fs;
                  end else begin
                    kind = (opc == OPC_ADD) ? K_ADD : ((opc == OPC_SUB) ? K_SUB : K_MUL);
                    fb   = fd;
                    fc   = {4'd0, fs};
                  end
                end
                OPC_SUM: begin
                  if (({1'b0, r16} >= NREG) || ({1'b0, lo16} >= NACC)) err = ST_RANGE;
                  kind = K_SUM;
                  fa   = lo16[3:0];
                  fb   = r16;
                end
                default: err = ST_UNSUPPORTED;
              endcase
              if (opc != OPC_LOADCONST && err == ST_OK) begin
                if (ops_r >= OPS_LIMIT) err = ST_TOOLARGE;
                else op_ok = 1'b1;
              end
              if (op_ok) begin
                ops_nxt = ops_r + 1'b1;
                res0    = mk_op(kind, fa, fb, fc, '0, 1'b0);
                n_res   = 2'd1;
              end
            end
            PH_LOW: begin
              low_nxt   = in_word;
              phase_nxt = PH_HIGH;
            end
            default: begin
              err_pos   = pstart_r;
              err_opc   = OPC_LOADCONST;
              phase_nxt = PH_INSTR;
              if (pchk_r == CHK_TYPE) err = ST_NONBIGINT;
              else if (pchk_r != CHK_OK) err = ST_RANGE;
              else if (ops_r >= OPS_LIMIT) err = ST_TOOLARGE;
              else begin
                // u16 fits in 16 unsigned bits, i16 negative has bits 63..15 all set
                if (cval[63:16] == '0) kind = K_U16CONST;
                else if (&cval[63:15]) kind = K_I16CONST;
                else kind = K_INTCONST;
                ops_nxt = ops_r + 1'b1;
                res0    = mk_op(kind, preg_r, '0, '0, cval, 1'b0);
                n_res   = 2'd1;
              end
            end
          endcase
        end

        if (err != ST_OK) begin
          res0  = mk_err(err, err_pos, err_opc);
          n_res = 2'd1;
          phase_nxt = in_is_last ? PH_INSTR : PH_DISCARD;
        end else if (in_is_last) begin
          if (phase_nxt != PH_INSTR) begin
            res0  = mk_err(ST_MALFORMED, pstart_nxt, OPC_LOADCONST);
            n_res = 2'd1;
          end else if (n_res == 2'd1) begin
            res1  = (ops_nxt >= OPS_LIMIT) ? mk_err(ST_TOOLARGE, wp_nxt, '0)
                                            : mk_op(K_EXIT, '0, '0, '0, '0, 1'b1);
            n_res = 2'd2;
          end else begin
            res0  = (ops_nxt >= OPS_LIMIT) ? mk_err(ST_TOOLARGE, wp_nxt, '0)
                                            : mk_op(K_EXIT, '0, '0, '0, '0, 1'b1);
            n_res = 2'd1;
          end
        end

        // program over: back to the start state
        if (in_is_last) begin
          phase_nxt  = PH_INSTR;
          wp_nxt     = '0;
          ops_nxt    = '0;
          preg_nxt   = '0;
          pchk_nxt   = CHK_OK;
          pstart_nxt = '0;
          low_nxt    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_INSTR;
      wp_r     <= '0;
      ops_r    <= '0;
      preg_r   <= '0;
      pchk_r   <= CHK_OK;
      pstart_r <= '0;
      low_r    <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      wp_r     <= wp_nxt;
      ops_r    <= ops_nxt;
      preg_r   <= preg_nxt;
      pchk_r   <= pchk_nxt;
      pstart_r <= pstart_nxt;
      low_r    <= low_nxt;
      tail_r   <= tail_r + QP_W'(n_res);
      if (out_acc) head_r <= head_r + 1'b1;
      count_r  <= count_r + QC_W'(n_res) - QC_W'(out_acc);
    end
    if (n_res != 2'd0) q_r[tail_r] <= res0;
    if (n_res == 2'd2) q_r[QP_W'(tail_r + 1'b1)] <= res1;
  end

  assign out_op_kind            = q_r[head_r].kind;
  assign out_dst_a              = q_r[head_r].dst_a;
  assign out_src_b              = q_r[head_r].src_b;
  assign out_src_c              = q_r[head_r].src_c;
  assign out_immediate          = q_r[head_r].imm;
  assign out_status             = q_r[head_r].status;
  assign out_offending_position = q_r[head_r].pos;
  assign out_offending_opcode   = q_r[head_r].opc;
  assign out_last               = q_r[head_r].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QC_W'(QDEPTH))
    else $error("result queue overflow");

  a_ops_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ops_r <= OPS_LIMIT)
    else $error("op count beyond limit");

  a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == PH_DISCARD) |=> count_r <= $past(count_r))
    else $error("discarded item produced a result");

  a_program_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_is_last) |=> (phase_r == PH_INSTR && ops_r == '0 && wp_r == '0))
    else $error("state not cleared at program end");

  a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_is_last && n_res != 2'd0 && res0.status != ST_OK)
      |=> phase_r == PH_DISCARD)
    else $error("error did not stop translation");

endmodule

// File: tb/abt_translation_checker.sv
module abt_translation_checker
  import abt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [WORD_W-1:0]       in_word,
  input  logic                    in_has_word,
  input  logic                    in_is_last,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [3:0]              out_op_kind,
  input  logic [3:0]              out_dst_a,
  input  logic [3:0]              out_src_b,
  input  logic [7:0]              out_src_c,
  input  logic signed [IMM_W-1:0] out_immediate,
  input  logic [2:0]              out_status,
  input  logic [POS_W-1:0]        out_offending_position,
  input  logic [OPC_W-1:0]        out_offending_opcode,
  input  logic                    out_last,
  output int                      mismatches,
  output int                      awaiting
);

  typedef enum logic [1:0] {
    DEC_OPCODE,
    DEC_IMM_LOW,
    DEC_IMM_HIGH,
    DEC_DISCARD
  } dec_phase_t;

  dec_phase_t       dec_phase;
  logic [POS_W-1:0] word_count;
  int unsigned      op_count;
  logic [3:0]       const_reg;
  logic [1:0]       const_check;
  logic [POS_W-1:0] const_start;
  logic [31:0]      const_low;
  res_t             expected_ops[$];
  int               fail_total = 0;

  assign mismatches = fail_total;

  function automatic res_t op_result(op_kind_t k, logic [3:0] a, logic [3:0] b,
                                     logic [7:0] c, logic [IMM_W-1:0] imm, logic fin);
    res_t r;
    r = '0;
    r.kind   = k;
    r.dst_a  = a;
    r.src_b  = b;
    r.src_c  = c;
    r.imm    = imm;
    r.status = ST_OK;
    r.last   = fin;
    return r;
  endfunction

  function automatic res_t error_result(status_t st, logic [POS_W-1:0] pos,
                                        logic [OPC_W-1:0] opc);
    res_t r;
    r = '0;
    r.kind   = K_U16CONST;
    r.status = st;
    r.pos    = pos;
    r.opc    = opc;
    r.last   = 1'b1;
    return r;
  endfunction

  task automatic restart_program();
    dec_phase   = DEC_OPCODE;
    word_count  = '0;
    op_count    = 0;
    const_reg   = '0;
    const_check = CHK_OK;
    const_start = '0;
    const_low   = '0;
  endtask

  task automatic translate_item(input logic [WORD_W-1:0] w, input logic has,
                                input logic fin);
    logic [OPC_W-1:0] opc;
    logic [4:0]       wtype;
    logic [3:0]       rnum;
    logic [3:0]       dnum;
    logic [3:0]       snum;
    logic [15:0]      low_half;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] err_pos;
    logic [OPC_W-1:0] err_opc;
    logic [63:0]      value;
    status_t          err;
    op_kind_t         kind;
    logic [3:0]       fa;
    logic [3:0]       fb;
    logic [7:0]       fc;
    // after an error everything up to the end mark is swallowed
    if (dec_phase == DEC_DISCARD) begin
      if (fin) restart_program();
      return;
    end
    err     = ST_OK;
    err_pos = '0;
    err_opc = '0;
    if (has) begin
      pos = word_count;
      if (word_count < DEF_MAX_PROGRAM_WORDS) word_count++;
      case (dec_phase)
        DEC_OPCODE: begin
          opc      = w[31:26];
          wtype    = w[25:21];
          rnum     = w[19:16];
          low_half = w[15:0];
          dnum     = w[15:12];
          snum     = w[11:8];
          kind     = K_EXIT;
          fa       = '0;
          fb       = '0;
          fc       = '0;
          err_pos  = pos;
          err_opc  = opc;
          case (opc)
            OPC_LOADCONST: begin
              // checks are held back until the last immediate word
              const_reg = rnum;
              if (wtype != TYPE_BIGINT) const_check = CHK_TYPE;
              else if (rnum >= DEF_NUM_REGISTERS) const_check = CHK_RANGE;
              else const_check = CHK_OK;
              const_start = pos;
              dec_phase   = DEC_IMM_LOW;
            end
            OPC_LOADCOL: begin
              if (wtype != TYPE_BIGINT) err = ST_NONBIGINT;
              else if (rnum >= DEF_NUM_REGISTERS || low_half > 255) err = ST_RANGE;
              kind = K_LOADCOL;
              fa   = rnum;
              fc   = low_half[7:0];
            end
            OPC_MOV, OPC_ADD, OPC_SUB, OPC_MUL: begin
              if (dnum >= DEF_NUM_REGISTERS || snum >= DEF_NUM_REGISTERS) err = ST_RANGE;
              if (opc == OPC_MOV) begin
                kind = K_MOV;
                fa   = dnum;
                fb   = snum;
              end else begin
                fa = dnum;
                fb = dnum;
                fc = {4'h0, snum};
                if (opc == OPC_ADD) kind = K_ADD;
                else if (opc == OPC_SUB) kind = K_SUB;
                else kind = K_MUL;
              end
            end
            OPC_SUM: begin
              if (rnum >= DEF_NUM_REGISTERS || low_half >= DEF_NUM_ACCUMULATORS) err = ST_RANGE;
              kind = K_SUM;
              fa   = low_half[3:0];
              fb   = rnum;
            end
            default: err = ST_UNSUPPORTED;
          endcase
          if (opc != OPC_LOADCONST && err == ST_OK) begin
            if (op_count >= DEF_MAX_OPS) begin
              err = ST_TOOLARGE;
            end else begin
              op_count++;
              expected_ops.push_back(op_result(kind, fa, fb, fc, '0, 1'b0));
            end
          end
        end
        DEC_IMM_LOW: begin
          const_low = w;
          dec_phase = DEC_IMM_HIGH;
        end
        default: begin
          value     = {w, const_low};
          err_pos   = const_start;
          err_opc   = OPC_LOADCONST;
          dec_phase = DEC_OPCODE;
          if (const_check == CHK_TYPE) begin
            err = ST_NONBIGINT;
          end else if (const_check != CHK_OK) begin
            err = ST_RANGE;
          end else if (op_count >= DEF_MAX_OPS) begin
            err = ST_TOOLARGE;
          end else begin
            if (value <= 64'hFFFF) kind = K_U16CONST;
            else if (value >= 64'hFFFF_FFFF_FFFF_8000) kind = K_I16CONST;
            else kind = K_INTCONST;
            op_count++;
            expected_ops.push_back(op_result(kind, const_reg, '0, '0, value, 1'b0));
          end
        end
      endcase
    end
    if (err != ST_OK) begin
      expected_ops.push_back(error_result(err, err_pos, err_opc));
      if (fin) restart_program();
      else dec_phase = DEC_DISCARD;
      return;
    end
    if (fin) begin
      if (dec_phase != DEC_OPCODE)
        expected_ops.push_back(error_result(ST_MALFORMED, const_start, OPC_LOADCONST));
      else if (op_count >= DEF_MAX_OPS)
        expected_ops.push_back(error_result(ST_TOOLARGE, word_count, '0));
      else
        expected_ops.push_back(op_result(K_EXIT, '0, '0, '0, '0, 1'b1));
      restart_program();
    end
  endtask

  task automatic check_field(input string name, input logic [IMM_W-1:0] want,
                             input logic [IMM_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_total++;
    end
  endtask

  task automatic check_result();
    res_t want;
    if (expected_ops.size() == 0) begin
      $error("unexpected result: op_kind %0d status %0d", out_op_kind, out_status);
      fail_total++;
      return;
    end
    want = expected_ops.pop_front();
    check_field("op_kind", 64'(want.kind), 64'(out_op_kind));
    check_field("dst_a", 64'(want.dst_a), 64'(out_dst_a));
    check_field("src_b", 64'(want.src_b), 64'(out_src_b));
    check_field("src_c", 64'(want.src_c), 64'(out_src_c));
    check_field("immediate", want.imm, out_immediate);
    check_field("status", 64'(want.status), 64'(out_status));
    check_field("offending_position", 64'(want.pos), 64'(out_offending_position));
    check_field("offending_opcode", 64'(want.opc), 64'(out_offending_opcode));
    check_field("last", 64'(want.last), 64'(out_last));
  endtask

  // results of an item are registered in the result queue before they leave, so compare before predicting
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_program();
      expected_ops.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) translate_item(in_word, in_has_word, in_is_last);
    end
    awaiting <= expected_ops.size();
  end

endmodule

// File: tb/aggregation_bytecode_translator_top_test.sv
module aggregation_bytecode_translator_top_test
  import abt_pkg::*;
();

  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 20;
  localparam int PHASE_ITEMS     = 470;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              has;
    logic              fin;
  } bc_item_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [WORD_W-1:0]       in_word;
  logic                    in_has_word;
  logic                    in_is_last;
  logic                    out_valid;
  logic                    out_stall;
  logic [3:0]              out_op_kind;
  logic [3:0]              out_dst_a;
  logic [3:0]              out_src_b;
  logic [7:0]              out_src_c;
  logic signed [IMM_W-1:0] out_immediate;
  logic [2:0]              out_status;
  logic [POS_W-1:0]        out_offending_position;
  logic [OPC_W-1:0]        out_offending_opcode;
  logic                    out_last;

  int       mismatches;
  int       awaiting;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  bit       hold_request = 1'b0;
  int       cycle_count = 0;
  int       items_sent = 0;
  bc_item_t program_items[$];
  logic [OPC_W-1:0] reg_opcodes[4] = '{OPC_MOV, OPC_ADD, OPC_SUB, OPC_MUL};

  aggregation_bytecode_translator_top i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_word                (in_word),
    .in_has_word            (in_has_word),
    .in_is_last             (in_is_last),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_op_kind            (out_op_kind),
    .out_dst_a              (out_dst_a),
    .out_src_b              (out_src_b),
    .out_src_c              (out_src_c),
    .out_immediate          (out_immediate),
    .out_status             (out_status),
    .out_offending_position (out_offending_position),
    .out_offending_opcode   (out_offending_opcode),
    .out_last               (out_last)
  );

  abt_translation_checker i_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_word                (in_word),
    .in_has_word            (in_has_word),
    .in_is_last             (in_is_last),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_op_kind            (out_op_kind),
    .out_dst_a              (out_dst_a),
    .out_src_b              (out_src_b),
    .out_src_c              (out_src_c),
    .out_immediate          (out_immediate),
    .out_status             (out_status),
    .out_offending_position (out_offending_position),
    .out_offending_opcode   (out_offending_opcode),
    .out_last               (out_last),
    .mismatches             (mismatches),
    .awaiting               (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, or one long hold-off when asked for
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [WORD_W-1:0] w, input logic has, input logic fin);
    // each idle cycle is drawn on its own
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_word     <= w;
    in_has_word <= has;
    in_is_last  <= fin;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  function automatic logic [63:0] random_immediate();
    case ($urandom_range(7))
      0: return 64'($urandom_range(16'hFFFF));
      1: return 64'hFFFF;
      2: return 64'h1_0000;
      3: return 64'hFFFF_FFFF_FFFF_8000;
      4: return 64'hFFFF_FFFF_FFFF_7FFF;
      5: return {48'hFFFF_FFFF_FFFF, 1'b1, 15'($urandom())};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic push_item(input logic [WORD_W-1:0] w, input logic has, input logic fin);
    bc_item_t it;
    it.word = w;
    it.has  = has;
    it.fin  = fin;
    program_items.push_back(it);
  endtask

  task automatic push_const(input logic [4:0] wtype, input logic [63:0] imm);
    push_item({OPC_LOADCONST, wtype, 1'($urandom()), 4'($urandom()), 16'($urandom())},
              1'b1, 1'b0);
    push_item(imm[31:0], 1'b1, 1'b0);
    push_item(imm[63:32], 1'b1, 1'b0);
  endtask

  task automatic mark_last();
    bc_item_t it;
    it = program_items.pop_back();
    it.fin = 1'b1;
    program_items.push_back(it);
  endtask

  task automatic send_program();
    foreach (program_items[k])
      send_item(program_items[k].word, program_items[k].has, program_items[k].fin);
    program_items.delete();
  endtask

  task automatic push_good_instr();
    int unsigned sel;
    sel = $urandom_range(7);
    case (sel)
      0: push_item({OPC_LOADCOL, TYPE_BIGINT, 1'($urandom()), 4'($urandom()), 8'h00,
                    8'($urandom())}, 1'b1, 1'b0);
      1, 2, 3, 4: push_item({reg_opcodes[2'(sel - 1)], 10'($urandom()), 4'($urandom()),
                             4'($urandom()), 8'($urandom())}, 1'b1, 1'b0);
      5: push_item({OPC_SUM, 6'($urandom()), 4'($urandom()), 14'h0, 2'($urandom())},
                   1'b1, 1'b0);
      default: push_const(TYPE_BIGINT, random_immediate());
    endcase
  endtask

  task automatic push_bad_instr();
    logic [4:0]       wtype;
    logic [OPC_W-1:0] opc;
    case ($urandom_range(5))
      0: begin
        wtype = 5'($urandom());
        if (wtype == TYPE_BIGINT) wtype = 5'd0;
        push_item({OPC_LOADCOL, wtype, 1'($urandom()), 4'($urandom()), 16'($urandom())},
                  1'b1, 1'b0);
      end
      1: push_item({OPC_LOADCOL, TYPE_BIGINT, 1'($urandom()), 4'($urandom()),
                    16'($urandom_range(16'hFFFF, 256))}, 1'b1, 1'b0);
      2: push_item({OPC_SUM, 6'($urandom()), 4'($urandom()),
                    16'($urandom_range(16'hFFFF, 4))}, 1'b1, 1'b0);
      3: begin
        wtype = 5'($urandom());
        if (wtype == TYPE_BIGINT) wtype = 5'd31;
        push_const(wtype, random_immediate());
      end
      4: begin
        opc = $urandom_range(1) ? 6'($urandom_range(63, 25)) : 6'($urandom_range(6, 0));
        push_item({opc, 26'($urandom())}, 1'b1, 1'b0);
      end
      default: push_item($urandom(), 1'b1, 1'b0);
    endcase
  endtask

  // end mark on the last word, on an empty item, or inside a load-constant
  task automatic finish_program();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 2) begin
      push_item($urandom(), 1'b0, 1'b1);
    end else if (pick == 2) begin
      push_item({OPC_LOADCONST, TYPE_BIGINT, 1'($urandom()), 4'($urandom()),
                 16'($urandom())}, 1'b1, 1'b0);
      if ($urandom_range(1)) push_item($urandom(), 1'b1, 1'b0);
      if ($urandom_range(1)) mark_last();
      else push_item($urandom(), 1'b0, 1'b1);
    end else begin
      mark_last();
    end
  endtask

  task automatic random_program();
    int unsigned pick;
    repeat ($urandom_range(12, 1)) begin
      pick = $urandom_range(99);
      if (pick < 6) push_bad_instr();
      else if (pick < 10) push_item($urandom(), 1'b0, 1'b0);
      else push_good_instr();
    end
    finish_program();
    send_program();
  endtask

  // fills the op store, then overflows it at exit, on a single op or on a constant
  task automatic long_program(input int tail);
    repeat (DEF_MAX_OPS) push_good_instr();
    case (tail)
      0: mark_last();
      1: begin
        push_item({OPC_MUL, 26'($urandom())}, 1'b1, 1'b0);
        finish_program();
      end
      default: begin
        push_const(TYPE_BIGINT, random_immediate());
        finish_program();
      end
    endcase
    send_program();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_word     = '0;
    in_has_word = 1'b0;
    in_is_last  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty program
    push_item('0, 1'b0, 1'b1);
    send_program();
    // every op kind with in-range fields, plus the constant classes
    push_item({OPC_LOADCOL, TYPE_BIGINT, 1'b0, 4'hF, 16'd255}, 1'b1, 1'b0);
    push_item({OPC_MOV, 10'h000, 4'hF, 4'h0, 8'h00}, 1'b1, 1'b0);
    push_item({OPC_ADD, 10'h3FF, 4'h0, 4'hF, 8'hFF}, 1'b1, 1'b0);
    push_item({OPC_SUB, 10'h000, 4'h7, 4'h8, 8'h00}, 1'b1, 1'b0);
    push_item({OPC_MUL, 10'h155, 4'hA, 4'h5, 8'h55}, 1'b1, 1'b0);
    push_item({OPC_SUM, 6'h3F, 4'hF, 16'd3}, 1'b1, 1'b0);
    push_const(TYPE_BIGINT, 64'hFFFF);
    push_const(TYPE_BIGINT, 64'hFFFF_FFFF_FFFF_8000);
    push_const(TYPE_BIGINT, 64'h1_0000);
    mark_last();
    send_program();
    // wrong type on a load-column
    push_item({OPC_LOADCOL, 5'd8, 1'b0, 4'h0, 16'd0}, 1'b1, 1'b1);
    send_program();
    // column out of range, the following word is dropped
    push_item({OPC_LOADCOL, TYPE_BIGINT, 1'b0, 4'h1, 16'd256}, 1'b1, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_program();
    // accumulator out of range
    push_item({OPC_SUM, 6'h00, 4'h2, 16'd4}, 1'b1, 1'b1);
    send_program();
    // unknown opcode
    push_item({6'd63, 26'h3FF_FFFF}, 1'b1, 1'b1);
    send_program();
    // load-constant of a non-bigint type
    push_const(5'd0, 64'h1);
    mark_last();
    send_program();
    // program cut off inside a load-constant
    push_item({OPC_LOADCONST, TYPE_BIGINT, 1'b0, 4'h3, 16'h0000}, 1'b1, 1'b0);
    push_item('0, 1'b0, 1'b1);
    send_program();
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 59;
          hold_request  = 1'b1;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      long_program(ph);
      while (items_sent < (ph + 1) * PHASE_ITEMS) random_program();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
sv/abt_pkg.sv
sv/aggregation_bytecode_translator_top.sv
tb/abt_translation_checker.sv
tb/aggregation_bytecode_translator_top_test.sv
